/* rtl/bbeq_pkg.sv */
package bbeq_pkg;

    localparam int BTN_W      = 32;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 200;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 34;
    localparam int DEB_W      = 16;

    // input tuser codes
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_RESYNC = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MASK      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUSIVE_LATCH   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_ENABLE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_WORD      = 4'd7;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

    // shared timing control for the per-button hold cells
    typedef struct packed {
        logic             take;       // an item is processed this cycle
        logic             active;     // tick is not bouncing
        logic [BTN_W-1:0] now;
        logic [BTN_W-1:0] long_ticks;
        logic [BTN_W-1:0] rep_ticks;
    } t_hold_ctl;

    // keep only the highest set bit
    function automatic logic [BTN_W-1:0] highest_onehot(input logic [BTN_W-1:0] x);
        logic [BTN_W-1:0] rev;
        logic [BTN_W-1:0] low;
        logic [BTN_W-1:0] res;
        for (int i = 0; i < BTN_W; i++) begin
            rev[i] = x[BTN_W-1-i];
        end
        low = rev & (~rev + {{(BTN_W-1){1'b0}}, 1'b1});
        for (int i = 0; i < BTN_W; i++) begin
            res[i] = low[BTN_W-1-i];
        end
        return res;
    endfunction

endpackage

/* rtl/button_bank_event_qualifier.sv */
// Button bank event qualifier. Each request on the slave stream is one
// millisecond tick (tuser = 0) carrying the raw active-low pin word, or a
// resync (tuser = 1) that loads the debounced, last-raw and latch words from
// the pins with no events. Every request yields exactly one result on the
// master stream: debounced state, press and release edges, latch word,
// long-press and auto-repeat events and the combination event. The block
// takes one request per clock while the master stream does not stall; the
// whole tick update (debounce compare, edge and latch logic, and the per-button
// hold timers compared in parallel) is combinational between the input
// register and the result register, which is what sets the one-per-clock
// rate. Configuration writes are always ready and must be issued while no
// request is in flight. Registers: 0 debounce_ticks,
// 1 inverse_mask, 2 exclusive_latch, 3 long_press_ticks, 4 long_press_enable,
// 5 repeat_ticks, 6 repeat_enable, 7 combine_word (mask, exclusive bit 32,
// enable bit 33); other indexes are ignored.
module button_bank_event_qualifier #(
    parameter int NUM_BUTTONS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: [31:0] pin_levels
    input  logic [bbeq_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: [0] action
    input  logic                             i_s_axis_tuser,
    // master stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: [31:0] stable_state, [63:32] press_events, [95:64] release_events,
    // [127:96] latch_state, [159:128] long_press_events,
    // [191:160] repeat_events, [192] combine_event, [199:193] zero
    output logic [bbeq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bbeq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bbeq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bbeq_pkg::*;

    localparam logic [BTN_W-1:0] BTN_MASK = {BTN_W{1'b1}} >> (BTN_W - NUM_BUTTONS);

    // configuration
    logic [DEB_W-1:0] r_debounce;
    logic [BTN_W-1:0] r_inv_mask;
    logic             r_excl_latch;
    logic [BTN_W-1:0] r_long_ticks;
    logic [BTN_W-1:0] r_long_en;
    logic [BTN_W-1:0] r_rep_ticks;
    logic [BTN_W-1:0] r_rep_en;
    logic [BTN_W-1:0] r_comb_mask;
    logic             r_comb_excl;
    logic             r_comb_en;

    // tick state
    logic [BTN_W-1:0] r_tick_now;
    logic [BTN_W-1:0] r_last_raw;
    logic [BTN_W-1:0] r_bounce_start;
    logic [BTN_W-1:0] r_stable;
    logic [BTN_W-1:0] r_latch;
    logic             r_combine_active;

    // input register
    logic             r_in_valid;
    logic             r_in_action;
    logic [BTN_W-1:0] r_in_pins;

    // result register
    logic             r_out_valid;
    logic [BTN_W-1:0] r_out_stable;
    logic [BTN_W-1:0] r_out_press;
    logic [BTN_W-1:0] r_out_release;
    logic [BTN_W-1:0] r_out_latch;
    logic [BTN_W-1:0] r_out_long;
    logic [BTN_W-1:0] r_out_rep;
    logic             r_out_cev;

    // next values
    logic [BTN_W-1:0] n_tick_now;
    logic [BTN_W-1:0] n_last_raw;
    logic [BTN_W-1:0] n_bounce_start;
    logic [BTN_W-1:0] n_stable;
    logic [BTN_W-1:0] n_latch;
    logic             n_combine_active;

    logic             take;
    logic [BTN_W-1:0] reading;
    logic [BTN_W-1:0] now;
    logic             raw_chg;
    logic [BTN_W-1:0] last_eff;
    logic [BTN_W-1:0] bounce_eff;
    logic             bouncing;
    logic             is_tick;
    logic             hold_step;
    logic [BTN_W-1:0] changed;
    logic [BTN_W-1:0] press;
    logic [BTN_W-1:0] release_ev;
    logic             comb_match;
    logic             cev;
    logic [BTN_W-1:0] long_ev;
    logic [BTN_W-1:0] rep_ev;
    t_hold_ctl        hold_ctl;

    // advance the input register into the result register when it is free
    assign take            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || take;
    assign o_cfg_ready     = 1'b1;

    always_comb begin
        reading    = (~r_in_pins ^ r_inv_mask) & BTN_MASK;
        now        = r_tick_now + {{(BTN_W-1){1'b0}}, 1'b1};
        raw_chg    = reading != r_last_raw;
        last_eff   = raw_chg ? reading : r_last_raw;
        bounce_eff = raw_chg ? now : r_bounce_start;
        bouncing   = (now - bounce_eff) < {{(BTN_W-DEB_W){1'b0}}, r_debounce};
        is_tick    = r_in_action == ACT_TICK;
        hold_step  = is_tick && !bouncing;

        // edges only once the raw word has settled
        changed    = hold_step ? (r_stable ^ last_eff) : '0;
        press      = changed & last_eff;
        release_ev = changed & ~last_eff;

        comb_match = ((last_eff & r_comb_mask) == r_comb_mask)
                     && (!r_comb_excl || (last_eff == r_comb_mask));
        cev        = 1'b0;
        n_combine_active = r_combine_active;
        if ((changed != '0) && r_comb_en) begin
            if (comb_match) begin
                cev              = !r_combine_active;
                n_combine_active = 1'b1;
            end else begin
                n_combine_active = 1'b0;
            end
        end

        n_latch = r_latch;
        if (press != '0) begin
            n_latch = r_excl_latch ? highest_onehot(press) : (r_latch ^ press);
        end

        n_stable       = hold_step ? last_eff : r_stable;
        n_tick_now     = now;
        n_last_raw     = last_eff;
        n_bounce_start = bounce_eff;

        // resync: load words from the pins, hold time and bounce start
        if (!is_tick) begin
            n_stable         = reading;
            n_last_raw       = reading;
            n_latch          = reading;
            n_tick_now       = r_tick_now;
            n_bounce_start   = r_bounce_start;
            n_combine_active = r_combine_active;
        end
    end

    assign hold_ctl.take       = take;
    assign hold_ctl.active     = hold_step;
    assign hold_ctl.now        = now;
    assign hold_ctl.long_ticks = r_long_ticks;
    assign hold_ctl.rep_ticks  = r_rep_ticks;

    // one hold cell per button; unused upper bits stay quiet
    for (genvar g = 0; g < BTN_W; g++) begin : g_btn
        if (g < NUM_BUTTONS) begin : g_used
            bbeq_button u_button (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (hold_ctl),
                .i_press (press[g]),
                .i_held  (last_eff[g]),
                .i_lp_en (r_long_en[g]),
                .i_rp_en (r_rep_en[g]),
                .o_long  (long_ev[g]),
                .o_rep   (rep_ev[g])
            );
        end else begin : g_unused
            assign long_ev[g] = 1'b0;
            assign rep_ev[g]  = 1'b0;
        end
    end

    // configuration and tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce       <= DEBOUNCE_RESET;
            r_inv_mask       <= '0;
            r_excl_latch     <= 1'b0;
            r_long_ticks     <= '0;
            r_long_en        <= '0;
            r_rep_ticks      <= '0;
            r_rep_en         <= '0;
            r_comb_mask      <= '0;
            r_comb_excl      <= 1'b0;
            r_comb_en        <= 1'b0;
            r_tick_now       <= '0;
            r_last_raw       <= '0;
            r_bounce_start   <= '0;
            r_stable         <= '0;
            r_latch          <= '0;
            r_combine_active <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DEBOUNCE_TICKS:    r_debounce   <= i_cfg_data[DEB_W-1:0];
                    REG_INVERSE_MASK:      r_inv_mask   <= i_cfg_data[BTN_W-1:0];
                    REG_EXCLUSIVE_LATCH:   r_excl_latch <= i_cfg_data[0];
                    REG_LONG_PRESS_TICKS:  r_long_ticks <= i_cfg_data[BTN_W-1:0];
                    REG_LONG_PRESS_ENABLE: r_long_en    <= i_cfg_data[BTN_W-1:0];
                    REG_REPEAT_TICKS:      r_rep_ticks  <= i_cfg_data[BTN_W-1:0];
                    REG_REPEAT_ENABLE:     r_rep_en     <= i_cfg_data[BTN_W-1:0];
                    REG_COMBINE_WORD: begin
                        r_comb_mask <= i_cfg_data[BTN_W-1:0];
                        r_comb_excl <= i_cfg_data[BTN_W];
                        r_comb_en   <= i_cfg_data[BTN_W+1];
                    end
                    default: ;
                endcase
            end
            if (take) begin
                r_tick_now       <= n_tick_now;
                r_last_raw       <= n_last_raw;
                r_bounce_start   <= n_bounce_start;
                r_stable         <= n_stable;
                r_latch          <= n_latch;
                r_combine_active <= n_combine_active;
            end
        end
    end

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_action <= i_s_axis_tuser;
            r_in_pins   <= i_s_axis_tdata;
        end
        if (take) begin
            r_out_stable  <= n_stable;
            r_out_press   <= press;
            r_out_release <= release_ev;
            r_out_latch   <= n_latch;
            r_out_long    <= long_ev;
            r_out_rep     <= rep_ev;
            r_out_cev     <= cev;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_cev, r_out_rep, r_out_long, r_out_latch,
                              r_out_release, r_out_press, r_out_stable};

    // edges agree with the debounced word they are reported with
    a_edges_match_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (((r_out_press & ~r_out_stable) == '0)
                         && ((r_out_release & r_out_stable) == '0)))
        else $error("press/release events disagree with stable state");

    // a tick advances time by exactly one
    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (r_in_action == ACT_TICK)) |=> (r_tick_now == $past(r_tick_now) + 32'd1))
        else $error("tick did not advance time by one");

    // a resync leaves time alone
    a_resync_holds_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (r_in_action == ACT_RESYNC)) |=> $stable(r_tick_now))
        else $error("resync changed time base");

    // a combination event arms the combination
    a_combine_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && cev) |=> (r_combine_active && r_out_cev))
        else $error("combination event without active combination");

endmodule

/* rtl/bbeq_button.sv */
module bbeq_button (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bbeq_pkg::t_hold_ctl   i_ctl,
    input  logic                  i_press,
    input  logic                  i_held,
    input  logic                  i_lp_en,
    input  logic                  i_rp_en,
    output logic                  o_long,
    output logic                  o_rep
);
    import bbeq_pkg::*;

    logic [BTN_W-1:0] r_press_stamp;
    logic [BTN_W-1:0] r_repeat_stamp;
    logic             r_long_fired;

    logic [BTN_W-1:0] press_eff;
    logic [BTN_W-1:0] repeat_eff;
    logic             fired_eff;
    logic [BTN_W-1:0] press_age;
    logic [BTN_W-1:0] repeat_age;

    // a fresh press restarts both timers this tick
    always_comb begin
        press_eff  = i_press ? i_ctl.now : r_press_stamp;
        repeat_eff = i_press ? i_ctl.now : r_repeat_stamp;
        fired_eff  = i_press ? 1'b0 : r_long_fired;
        press_age  = i_ctl.now - press_eff;
        repeat_age = i_ctl.now - repeat_eff;
        o_long = i_ctl.active && i_held && i_lp_en && !fired_eff
                 && (press_age >= i_ctl.long_ticks);
        o_rep  = i_ctl.active && i_held && i_rp_en && (repeat_age >= i_ctl.rep_ticks);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_stamp  <= '0;
            r_repeat_stamp <= '0;
            r_long_fired   <= 1'b0;
        end else if (i_ctl.take && i_ctl.active) begin
            r_press_stamp  <= press_eff;
            r_repeat_stamp <= o_rep ? i_ctl.now : repeat_eff;
            r_long_fired   <= fired_eff | o_long;
        end
    end

endmodule
